// ===== rtl/xxh64_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh64_pkg
// shared constants and types for the streaming 64-bit xxhash block
// ----------------------------------------------------------------------------
package xxh64_pkg;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  // multiply request toward the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // multiply response, product valid while done is high
  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

// ===== rtl/xxh_in_if.sv =====
// ----------------------------------------------------------------------------
// xxh_in_if
// message word channel: valid/ready with data word, byte count and last flag
// ----------------------------------------------------------------------------
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

// ===== rtl/xxh_out_if.sv =====
// ----------------------------------------------------------------------------
// xxh_out_if
// hash result channel: valid/ready with the 64-bit hash
// ----------------------------------------------------------------------------
interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

// ===== rtl/xxh_cfg_if.sv =====
// ----------------------------------------------------------------------------
// xxh_cfg_if
// configuration write channel carrying the seed register value
// ----------------------------------------------------------------------------
interface xxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

// ===== rtl/xxhash64_stream.sv =====
// ----------------------------------------------------------------------------
// xxhash64_stream
// streaming 64-bit xxhash over little-endian 8-byte message words
// ----------------------------------------------------------------------------
// a buffered word is only stored; a word that closes a stripe updates the
//   four lanes, two multiplies each
// the final word runs the multiplies of merge, tails and avalanche in turn
//   until the hash sits in the output register
// all cost is set by the single shared 64-bit multiplier (3 partial products)
// sync active-low reset: idle, seed 0, empty buffer, zero length, no result
module xxhash64_stream (
  input  logic       clk,
  input  logic       rst_n,
  xxh_in_if.sink     in_ch,
  xxh_out_if.source  out_ch,
  xxh_cfg_if.sink    cfg_ch
);

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,  // waiting for a message word
    S_LANE   = 9'b000000010,  // stripe update, one lane at a time
    S_FSTART = 9'b000000100,  // pick long or short start of finalization
    S_MERGE  = 9'b000001000,  // fold the four lanes in
    S_TAILW  = 9'b000010000,  // 8-byte tail words
    S_TAIL4  = 9'b000100000,  // 4-byte tail
    S_TAILB  = 9'b001000000,  // single byte tails
    S_AVAL   = 9'b010000000,  // avalanche
    S_OUT    = 9'b100000000   // hand hash to the output register
  } state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  state_t      state_r, state_nxt;
  logic [1:0]  sub_r, sub_nxt;        // step within one round
  logic [1:0]  idx_r, idx_nxt;        // lane / tail word index
  logic [2:0]  pos_r, pos_nxt;        // byte position for single byte tails
  logic        issue_r, issue_nxt;    // start a multiply this cycle
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] lane_nxt [4];
  logic [63:0] buf_r [3];
  logic [63:0] buf_nxt [3];
  logic [63:0] word_r, word_nxt;      // stripe's fourth word or masked last word
  logic [3:0]  bc_r, bc_nxt;          // clamped byte count of the last word
  logic [1:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic        inmsg_r, inmsg_nxt;
  logic        last_r, last_nxt;
  logic [63:0] seed_r;
  logic [63:0] hash_r, hash_nxt;
  logic        ovalid_r, ovalid_nxt;

  xxh64_pkg::mul_req_t mreq;
  xxh64_pkg::mul_rsp_t mrsp;

  logic [63:0] buf_sel, tail_src, masked;
  logic [3:0]  bcc;
  logic [2:0]  nwords;
  logic        in_take;
  state_t      route_st;              // where to go after the 8-byte tails
  logic [63:0] prod;

  xxh_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  assign prod    = mrsp.p;
  assign in_take = in_ch.valid && in_ch.ready;

  // buffered word at the current index, the held word past the buffer
  always_comb begin
    case (idx_r)
      2'd0:    buf_sel = buf_r[0];
      2'd1:    buf_sel = buf_r[1];
      2'd2:    buf_sel = buf_r[2];
      default: buf_sel = word_r;
    endcase
  end

  // tail words: the buffered ones, then the last word when it is full
  assign tail_src = (idx_r < fill_r) ? buf_sel : word_r;
  assign nwords   = {1'b0, fill_r} + {2'd0, (bc_r == 4'd8)};

  always_comb begin
    if (bc_r >= 4'd4 && bc_r < 4'd8) begin
      route_st = S_TAIL4;
    end else if (bc_r != 4'd0 && bc_r < 4'd8) begin
      route_st = S_TAILB;
    end else begin
      route_st = S_AVAL;
    end
  end

  // byte count clamp and masking of unused bytes
  always_comb begin
    bcc = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
    for (int k = 0; k < 8; k++) begin
      masked[k*8 +: 8] = (4'(k) < bcc) ? in_ch.data_word[k*8 +: 8] : 8'd0;
    end
  end

  // multiplier operands per step
  always_comb begin
    mreq.start = issue_r;
    mreq.a     = 64'd0;
    mreq.b     = 64'd0;
    unique case (state_r)
      S_LANE: begin
        mreq.a = (sub_r == 2'd0) ? buf_sel : t_r;
        mreq.b = (sub_r == 2'd0) ? xxh64_pkg::PRIME2 : xxh64_pkg::PRIME1;
      end
      S_MERGE: begin
        case (sub_r)
          2'd0:    begin mreq.a = lane_r[idx_r]; mreq.b = xxh64_pkg::PRIME2; end
          2'd1:    begin mreq.a = t_r;           mreq.b = xxh64_pkg::PRIME1; end
          default: begin mreq.a = acc_r;         mreq.b = xxh64_pkg::PRIME1; end
        endcase
      end
      S_TAILW: begin
        case (sub_r)
          2'd0:    begin mreq.a = tail_src;           mreq.b = xxh64_pkg::PRIME2; end
          2'd1:    begin mreq.a = t_r;                mreq.b = xxh64_pkg::PRIME1; end
          default: begin mreq.a = rotl(acc_r, 6'd27); mreq.b = xxh64_pkg::PRIME1; end
        endcase
      end
      S_TAIL4: begin
        mreq.a = (sub_r == 2'd0) ? {32'd0, word_r[31:0]} : rotl(acc_r, 6'd23);
        mreq.b = (sub_r == 2'd0) ? xxh64_pkg::PRIME1 : xxh64_pkg::PRIME2;
      end
      S_TAILB: begin
        mreq.a = (sub_r == 2'd0) ? {56'd0, word_r[{pos_r, 3'b000} +: 8]}
                                 : rotl(acc_r, 6'd11);
        mreq.b = (sub_r == 2'd0) ? xxh64_pkg::PRIME5 : xxh64_pkg::PRIME1;
      end
      S_AVAL: begin
        mreq.a = (sub_r == 2'd0) ? (acc_r ^ (acc_r >> 33)) : (acc_r ^ (acc_r >> 29));
        mreq.b = (sub_r == 2'd0) ? xxh64_pkg::PRIME2 : xxh64_pkg::PRIME3;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    sub_nxt    = sub_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    issue_nxt  = 1'b0;
    acc_nxt    = acc_r;
    t_nxt      = t_r;
    lane_nxt   = lane_r;
    buf_nxt    = buf_r;
    word_nxt   = word_r;
    bc_nxt     = bc_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    inmsg_nxt  = inmsg_r;
    last_nxt   = last_r;
    hash_nxt   = hash_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          // first word of a message: seed the lanes
          if (!inmsg_r) begin
            lane_nxt[0] = seed_r + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
            lane_nxt[1] = seed_r + xxh64_pkg::PRIME2;
            lane_nxt[2] = seed_r;
            lane_nxt[3] = seed_r - xxh64_pkg::PRIME1;
            inmsg_nxt   = 1'b1;
          end
          idx_nxt = 2'd0;
          sub_nxt = 2'd0;
          if (!in_ch.last) begin
            len_nxt = len_r + 64'd8;
            if (fill_r == 2'd3) begin
              // fourth word closes a stripe
              word_nxt  = in_ch.data_word;
              last_nxt  = 1'b0;
              issue_nxt = 1'b1;
              state_nxt = S_LANE;
            end else begin
              buf_nxt[fill_r] = in_ch.data_word;
              fill_nxt        = fill_r + 2'd1;
            end
          end else begin
            word_nxt = masked;
            len_nxt  = len_r + {60'd0, bcc};
            last_nxt = 1'b1;
            if (bcc == 4'd8 && fill_r == 2'd3) begin
              // full last word still closes a stripe, then no byte tail
              bc_nxt    = 4'd0;
              issue_nxt = 1'b1;
              state_nxt = S_LANE;
            end else begin
              bc_nxt    = bcc;
              state_nxt = S_FSTART;
            end
          end
        end
      end

      S_LANE: begin
        if (mrsp.done) begin
          issue_nxt = 1'b1;
          if (sub_r == 2'd0) begin
            t_nxt   = rotl(lane_r[idx_r] + prod, 6'd31);
            sub_nxt = 2'd1;
          end else begin
            lane_nxt[idx_r] = prod;
            sub_nxt         = 2'd0;
            idx_nxt         = idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              fill_nxt  = 2'd0;
              issue_nxt = 1'b0;
              state_nxt = last_r ? S_FSTART : S_IDLE;
            end
          end
        end
      end

      S_FSTART: begin
        sub_nxt   = 2'd0;
        idx_nxt   = 2'd0;
        pos_nxt   = 3'd0;
        issue_nxt = 1'b1;
        if (len_r >= 64'd32) begin
          acc_nxt   = rotl(lane_r[0], 6'd1) + rotl(lane_r[1], 6'd7) +
                      rotl(lane_r[2], 6'd12) + rotl(lane_r[3], 6'd18);
          state_nxt = S_MERGE;
        end else begin
          // short message starts from lane two, which holds the seed
          acc_nxt   = lane_r[2] + xxh64_pkg::PRIME5 + len_r;
          state_nxt = (nwords != 3'd0) ? S_TAILW : route_st;
        end
      end

      S_MERGE: begin
        if (mrsp.done) begin
          issue_nxt = 1'b1;
          case (sub_r)
            2'd0: begin
              t_nxt   = rotl(prod, 6'd31);
              sub_nxt = 2'd1;
            end
            2'd1: begin
              acc_nxt = acc_r ^ prod;
              sub_nxt = 2'd2;
            end
            default: begin
              sub_nxt = 2'd0;
              idx_nxt = idx_r + 2'd1;
              acc_nxt = prod + xxh64_pkg::PRIME4;
              if (idx_r == 2'd3) begin
                // length goes in after the last lane is folded
                acc_nxt   = prod + xxh64_pkg::PRIME4 + len_r;
                idx_nxt   = 2'd0;
                pos_nxt   = 3'd0;
                state_nxt = (nwords != 3'd0) ? S_TAILW : route_st;
              end
            end
          endcase
        end
      end

      S_TAILW: begin
        if (mrsp.done) begin
          issue_nxt = 1'b1;
          case (sub_r)
            2'd0: begin
              t_nxt   = rotl(prod, 6'd31);
              sub_nxt = 2'd1;
            end
            2'd1: begin
              acc_nxt = acc_r ^ prod;
              sub_nxt = 2'd2;
            end
            default: begin
              acc_nxt = prod + xxh64_pkg::PRIME4;
              sub_nxt = 2'd0;
              idx_nxt = idx_r + 2'd1;
              if ({1'b0, idx_r} + 3'd1 >= nwords) begin
                pos_nxt   = 3'd0;
                state_nxt = route_st;
              end
            end
          endcase
        end
      end

      S_TAIL4: begin
        if (mrsp.done) begin
          issue_nxt = 1'b1;
          if (sub_r == 2'd0) begin
            acc_nxt = acc_r ^ prod;
            sub_nxt = 2'd1;
          end else begin
            acc_nxt   = prod + xxh64_pkg::PRIME3;
            sub_nxt   = 2'd0;
            pos_nxt   = 3'd4;
            state_nxt = (bc_r > 4'd4) ? S_TAILB : S_AVAL;
          end
        end
      end

      S_TAILB: begin
        if (mrsp.done) begin
          issue_nxt = 1'b1;
          if (sub_r == 2'd0) begin
            acc_nxt = acc_r ^ prod;
            sub_nxt = 2'd1;
          end else begin
            acc_nxt = prod;
            sub_nxt = 2'd0;
            pos_nxt = pos_r + 3'd1;
            if ({1'b0, pos_r} + 4'd1 >= bc_r) begin
              state_nxt = S_AVAL;
            end
          end
        end
      end

      S_AVAL: begin
        if (mrsp.done) begin
          if (sub_r == 2'd0) begin
            acc_nxt   = prod;
            sub_nxt   = 2'd1;
            issue_nxt = 1'b1;
          end else begin
            acc_nxt   = prod ^ (prod >> 32);
            sub_nxt   = 2'd0;
            state_nxt = S_OUT;
          end
        end
      end

      S_OUT: begin
        // wait for the output register to free up
        if (!ovalid_r || out_ch.ready) begin
          hash_nxt   = acc_r;
          ovalid_nxt = 1'b1;
          fill_nxt   = 2'd0;
          len_nxt    = 64'd0;
          inmsg_nxt  = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issue_r  <= 1'b0;
      fill_r   <= 2'd0;
      len_r    <= 64'd0;
      inmsg_r  <= 1'b0;
      ovalid_r <= 1'b0;
      seed_r   <= 64'd0;
    end else begin
      state_r  <= state_nxt;
      issue_r  <= issue_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      inmsg_r  <= inmsg_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.seed;
      end
    end
    sub_r    <= sub_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    acc_r    <= acc_nxt;
    t_r      <= t_nxt;
    lane_r   <= lane_nxt;
    buf_r    <= buf_nxt;
    word_r   <= word_nxt;
    bc_r     <= bc_nxt;
    last_r   <= last_nxt;
    hash_r   <= hash_nxt;
  end

  // ports
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.hash  = hash_r;

endmodule

// ===== rtl/xxh_mul.sv =====
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 multiplier, low 64 bits, from three 32x32 partial products
// ----------------------------------------------------------------------------
module xxh_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  xxh64_pkg::mul_req_t req,
  output xxh64_pkg::mul_rsp_t rsp
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LL   = 4'b0010,
    M_HL   = 4'b0100,
    M_LH   = 4'b1000
  } mstate_t;

  mstate_t     step_r, step_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  logic        done_r, done_nxt;
  logic [31:0] x, y;
  logic [63:0] m;

  always_comb begin
    x = a_r[31:0];
    y = b_r[31:0];
    unique case (step_r)
      M_HL: x = a_r[63:32];
      M_LH: y = b_r[63:32];
      default: ;
    endcase
    m = {32'd0, x} * {32'd0, y};
  end

  always_comb begin
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    done_nxt = 1'b0;
    unique case (step_r)
      M_IDLE: begin
        if (req.start) begin
          a_nxt    = req.a;
          b_nxt    = req.b;
          step_nxt = M_LL;
        end
      end
      M_LL: begin
        p_nxt    = m;
        step_nxt = M_HL;
      end
      M_HL: begin
        p_nxt    = p_r + {m[31:0], 32'd0};
        step_nxt = M_LH;
      end
      M_LH: begin
        p_nxt    = p_r + {m[31:0], 32'd0};
        done_nxt = 1'b1;
        step_nxt = M_IDLE;
      end
      default: step_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

// ===== tb/xxh_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xxh_tb_pkg
// request record shared by the stimulus and driver of the xxhash testbench
// ----------------------------------------------------------------------------
package xxh_tb_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } word_req_t;

endpackage

// ===== tb/xxhash64_stream_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xxhash64_stream_test
// self-checking bench for the streaming xxh64 block: messages of random and
// corner-case lengths are hashed by an in-bench predictor and every returned
// hash is compared in order, under several idle and stall patterns and seeds
// ----------------------------------------------------------------------------
module xxhash64_stream_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  // idle / stall phases
  typedef enum logic [1:0] {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xxh_in_if  in_ch();
  xxh_out_if out_ch();
  xxh_cfg_if cfg_ch();

  xxhash64_stream DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: a copy of the hashing state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [63:0] seed_reg;
  logic [63:0] lanes[4];
  logic [63:0] pend_words[3];
  int unsigned pend_cnt;
  logic [63:0] bytes_seen;
  bit          msg_open;

  logic [63:0]            hash_q[$];
  xxh_tb_pkg::word_req_t  word_q[$];

  phase_t phase;
  bit     hold_off;
  bit     stim_done;
  int     errors;

  function automatic logic [63:0] rol(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_mix(input logic [63:0] a, input logic [63:0] v);
    return rol(a + v * xxh64_pkg::PRIME2, 31) * xxh64_pkg::PRIME1;
  endfunction

  function automatic logic [63:0] fold_word(input logic [63:0] a, input logic [63:0] w);
    a ^= lane_mix(64'd0, w);
    return rol(a, 27) * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
  endfunction

  task automatic absorb_stripe(input logic [63:0] w3);
    lanes[0] = lane_mix(lanes[0], pend_words[0]);
    lanes[1] = lane_mix(lanes[1], pend_words[1]);
    lanes[2] = lane_mix(lanes[2], pend_words[2]);
    lanes[3] = lane_mix(lanes[3], w3);
    pend_cnt = 0;
  endtask

  // advance the model by one accepted word; push a hash on a last word
  task automatic hash_word(input xxh_tb_pkg::word_req_t r);
    logic [63:0] w, total, acc;
    int unsigned n, pos;
    w = r.data_word;
    if (!msg_open) begin
      lanes[0] = seed_reg + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
      lanes[1] = seed_reg + xxh64_pkg::PRIME2;
      lanes[2] = seed_reg;
      lanes[3] = seed_reg - xxh64_pkg::PRIME1;
      msg_open = 1'b1;
    end
    if (!r.last) begin
      if (pend_cnt >= 3) absorb_stripe(w);
      else begin
        pend_words[pend_cnt] = w;
        pend_cnt++;
      end
      bytes_seen += 64'd8;
      return;
    end
    // oversized counts clip to a full word, stray upper bytes are masked
    n = (r.byte_count > 8) ? 8 : r.byte_count;
    if (n < 8) w &= (64'd1 << (8 * n)) - 64'd1;
    total = bytes_seen + n;
    if (n == 8 && pend_cnt >= 3) begin
      absorb_stripe(w);
      n = 0;
    end
    if (total >= 64'd32) begin
      acc = rol(lanes[0], 1) + rol(lanes[1], 7) +
            rol(lanes[2], 12) + rol(lanes[3], 18);
      for (int i = 0; i < 4; i++) begin
        acc ^= lane_mix(64'd0, lanes[i]);
        acc = acc * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
      end
    end else begin
      acc = lanes[2] + xxh64_pkg::PRIME5;
    end
    acc += total;
    for (int i = 0; i < pend_cnt; i++) acc = fold_word(acc, pend_words[i]);
    if (n == 8) begin
      acc = fold_word(acc, w);
    end else begin
      pos = 0;
      if (n >= 4) begin
        acc ^= (w & 64'hFFFF_FFFF) * xxh64_pkg::PRIME1;
        acc = rol(acc, 23) * xxh64_pkg::PRIME2 + xxh64_pkg::PRIME3;
        pos = 4;
      end
      for (; pos < n; pos++) begin
        acc ^= ((w >> (8 * pos)) & 64'hFF) * xxh64_pkg::PRIME5;
        acc = rol(acc, 11) * xxh64_pkg::PRIME1;
      end
    end
    // avalanche
    acc ^= acc >> 33;
    acc *= xxh64_pkg::PRIME2;
    acc ^= acc >> 29;
    acc *= xxh64_pkg::PRIME3;
    acc ^= acc >> 32;
    hash_q.push_back(acc);
    pend_cnt = 0;
    bytes_seen = 64'd0;
    msg_open = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued words, idles at random depending on the phase
  // ---------------------------------------------------------------------------
  function automatic bit src_idle();
    if (phase == PH_SRC_IDLE) return $urandom_range(99) < 85;
    if (phase == PH_BOTH) return $urandom_range(99) < 37;
    return 1'b0;
  endfunction

  function automatic bit snk_stall();
    if (hold_off) return 1'b1;
    if (phase == PH_SNK_STALL) return $urandom_range(99) < 85;
    if (phase == PH_BOTH) return $urandom_range(99) < 37;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    xxh_tb_pkg::word_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // keep the current request until it is taken
      if (in_ch.valid && in_ch.ready) begin
        hash_word(word_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // holding
      end else if (word_q.size() > 0 && !src_idle()) begin
        nxt = word_q[0];
        in_ch.valid      <= 1'b1;
        in_ch.data_word  <= nxt.data_word;
        in_ch.byte_count <= nxt.byte_count;
        in_ch.last       <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each returned hash against the oldest prediction
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hash_q.size() == 0) begin
          $display("%0t: unexpected hash, expected none, actual %h", $time, out_ch.hash);
          errors++;
        end else begin
          want = hash_q.pop_front();
          if (want !== out_ch.hash) begin
            $display("%0t: hash mismatch, expected %h, actual %h", $time, want, out_ch.hash);
            errors++;
          end
        end
      end
      out_ch.ready <= !snk_stall();
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("xxhash64_stream verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // queue a message of nfull full words and a last word of tail_bytes
  task automatic queue_msg(input int nfull, input int tail_bytes);
    xxh_tb_pkg::word_req_t r;
    for (int i = 0; i < nfull; i++) begin
      r.data_word = rnd64();
      r.byte_count = 4'($urandom_range(15));
      r.last = 1'b0;
      word_q.push_back(r);
    end
    r.data_word = rnd64();
    r.byte_count = 4'(tail_bytes);
    r.last = 1'b1;
    word_q.push_back(r);
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_ch.valid || hash_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    seed_reg = s;
    cfg_ch.valid <= 1'b0;
  endtask

  // random traffic: mostly short messages, a few long ones
  task automatic random_msgs(input int words);
    int n, nf;
    n = 0;
    while (n < words) begin
      nf = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
      queue_msg(nf, $urandom_range(15));
      n += nf + 1;
    end
  endtask

  initial begin
    xxh_tb_pkg::word_req_t r;
    errors = 0;
    phase = PH_FREE;
    hold_off = 1'b0;
    stim_done = 1'b0;
    seed_reg = 64'd0;
    pend_cnt = 0;
    bytes_seen = 64'd0;
    msg_open = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_word = 64'd0;
    in_ch.byte_count = 4'd0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.seed = 64'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, each short tail, stripe edges, full-ones words
    queue_msg(0, 0);
    for (int b = 1; b <= 8; b++) queue_msg(0, b);
    queue_msg(0, 15);
    queue_msg(3, 8);
    queue_msg(3, 0);
    queue_msg(4, 5);
    r.data_word = '1; r.byte_count = 4'hF; r.last = 1'b0;
    word_q.push_back(r);
    r.byte_count = 4'd8; r.last = 1'b1;
    word_q.push_back(r);
    r.data_word = '0; r.byte_count = 4'd0; r.last = 1'b1;
    word_q.push_back(r);
    drain();

    write_seed('1);
    queue_msg(0, 3);
    queue_msg(4, 8);
    // a last word with an oversized byte count of 9 is clipped to a full word
    queue_msg(1, 9);
    drain();

    write_seed(rnd64());
    phase = PH_FREE;
    random_msgs(100);
    drain();

    phase = PH_SRC_IDLE;
    random_msgs(80);
    drain();

    write_seed(64'd0);
    phase = PH_SNK_STALL;
    random_msgs(80);
    drain();

    write_seed(rnd64());
    phase = PH_BOTH;
    random_msgs(80);
    drain();

    // long receiver hold-off while the sender keeps offering words
    phase = PH_FREE;
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) queue_msg(0, $urandom_range(8));
    repeat (1500) @(posedge clk);
    hold_off = 1'b0;
    drain();

    if (errors == 0)
      $display("xxhash64_stream verification clean");
    else
      $display("xxhash64_stream verification failed");
    $finish;
  end

endmodule
